[src/jrah_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrah_pkg: shared types and constants for the jump-reset average filter
// Data width, configuration register indexes and reset values, and the
// control bundle that steers the row of window cells.
// ----------------------------------------------------------------------------
package jrah_pkg;

  // sample, average and position width
  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOffset    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgJumpLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldBand  = 2'd2;

  // register reset values
  localparam logic [DataW-1:0] OffsetRst    = 16'h0000;
  localparam logic [DataW-1:0] JumpLimitRst = 16'h0100;
  localparam logic [DataW-1:0] HoldBandRst  = 16'h0040;

  // per-request control for every window cell
  typedef struct packed {
    logic shift;   // take the neighbour's value
    logic refill;  // load the new sample (takes priority)
  } cell_ctrl_t;

endpackage : jrah_pkg
`default_nettype wire

[src/jrah_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrah_cell: one entry of the sample window
// Holds one sample. On a normal request it takes its neighbour's value; on a
// jump it loads the new sample directly.
// ----------------------------------------------------------------------------
module jrah_cell (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  jrah_pkg::cell_ctrl_t       ctrl_i,
  input  wire  [jrah_pkg::DataW-1:0] sample_i,
  input  wire  [jrah_pkg::DataW-1:0] prev_i,
  output logic [jrah_pkg::DataW-1:0] data_o
);
  import jrah_pkg::*;

  logic [DataW-1:0] data_q, data_d;

  // next value: refill beats shift
  always_comb begin
    data_d = data_q;
    if (ctrl_i.refill) begin
      data_d = sample_i;
    end else if (ctrl_i.shift) begin
      data_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule : jrah_cell
`default_nettype wire

[src/jrah_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jrah_out_buf: output register with skid stage
// Holds a finished result and one more, so the filter can take one more
// request while the consumer stalls.
// ----------------------------------------------------------------------------
module jrah_out_buf #(
  parameter int unsigned Width = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire              stall_i,
  output logic [Width-1:0] data_o
);

  logic             main_v_q, main_v_d;
  logic             skid_v_q, skid_v_d;
  logic [Width-1:0] main_q, main_d;
  logic [Width-1:0] skid_q, skid_d;
  logic             pop;

  assign pop = main_v_q & ~stall_i;

  // push is only given while the skid stage is empty
  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  // skid entry only exists behind a held result
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid stage holds data with empty output register");

  // a stalled result is not replaced
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_v_q && stall_i |=> main_v_q && main_q == $past(main_q))
    else $error("stalled result changed");

  // a full buffer drains into the output register
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !stall_i |=> main_q == $past(skid_q) && !skid_v_q)
    else $error("skid stage did not move forward");

endmodule : jrah_out_buf
`default_nettype wire

[src/jump_reset_average_hysteresis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// jump_reset_average_hysteresis: moving average with jump reset and hold band
// Windowed average of position samples with refill on large jumps, a
// hysteresis hold on the output and a wrapping offset.
// ----------------------------------------------------------------------------
// Takes one raw sample per clock cycle unless the skid stage is full and
// delivers its position result from the output register; the skid stage
// takes one more result while the consumer stalls. The rate is set by the
// update loop (jump compare, running sum, average by shift or constant
// reciprocal, hold compare), since each sample needs the average left by the
// previous one. The window is a row of WINDOW_LENGTH cells that shift per
// request or refill on a jump, so the entry dropped from the sum is always the
// oldest one at the end of the row. Registers (offset, jump limit, hold band)
// may be written only while the filter is idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module jump_reset_average_hysteresis #(
  parameter int unsigned WINDOW_LENGTH = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_we_i,
  input  wire  [jrah_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [jrah_pkg::DataW-1:0]   cfg_data_i,
  // sample requests
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [jrah_pkg::DataW-1:0]   raw_sample_i,
  // position results
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [jrah_pkg::DataW-1:0]   position_o
);
  import jrah_pkg::*;

  localparam int unsigned LenW  = $clog2(WINDOW_LENGTH);
  localparam int unsigned SumW  = DataW + LenW;
  // reciprocal for the non-power-of-two lengths: exact for every sum
  localparam int unsigned RecK  = SumW + LenW;
  localparam int unsigned RecW  = SumW + 1;
  localparam longint unsigned RecM =
    ((64'd1 << RecK) + longint'(WINDOW_LENGTH) - 64'd1) / longint'(WINDOW_LENGTH);
  localparam bit LenPow2 = ((1 << LenW) == WINDOW_LENGTH);

  function automatic logic [DataW-1:0] abs_diff(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration registers
  logic [DataW-1:0] offset_q, jump_limit_q, hold_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= OffsetRst;
      jump_limit_q <= JumpLimitRst;
      hold_band_q  <= HoldBandRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOffset:    offset_q     <= cfg_data_i;
        CfgJumpLimit: jump_limit_q <= cfg_data_i;
        CfgHoldBand:  hold_band_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state
  logic [SumW-1:0]  sum_q, sum_d;
  logic [DataW-1:0] avg_q, avg_d;
  logic [DataW-1:0] held_q, held_d;

  logic             accept;
  logic             jump;
  logic [DataW-1:0] oldest;
  logic [SumW-1:0]  sum_norm;
  logic [SumW-1:0]  sum_fill;
  logic [DataW-1:0] avg_norm;
  logic [DataW-1:0] position;
  cell_ctrl_t       cell_ctrl;

  assign accept = in_valid_i & ~in_stall_o;
  assign jump   = abs_diff(raw_sample_i, avg_q) > jump_limit_q;

  assign cell_ctrl.shift  = accept & ~jump;
  assign cell_ctrl.refill = accept & jump;

  // window row: cell 0 takes the new sample, the last one drops out
  logic [DataW-1:0] cell_data [WINDOW_LENGTH];

  for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_cell
    logic [DataW-1:0] prev;
    if (g == 0) begin : g_head
      assign prev = raw_sample_i;
    end else begin : g_body
      assign prev = cell_data[g-1];
    end
    jrah_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .sample_i (raw_sample_i),
      .prev_i   (prev),
      .data_o   (cell_data[g])
    );
  end

  assign oldest   = cell_data[WINDOW_LENGTH-1];
  assign sum_norm = sum_q - SumW'(oldest) + SumW'(raw_sample_i);
  assign sum_fill = SumW'(SumW'(raw_sample_i) * SumW'(WINDOW_LENGTH));

  // sum / WINDOW_LENGTH, truncated
  if (LenPow2) begin : g_avg_shift
    assign avg_norm = sum_norm[LenW +: DataW];
  end else begin : g_avg_recip
    logic [SumW+RecW-1:0] prod;
    assign prod     = (SumW+RecW)'(sum_norm) * (SumW+RecW)'(RecW'(RecM));
    assign avg_norm = prod[RecK +: DataW];
  end

  // next state
  always_comb begin
    if (jump) begin
      sum_d = sum_fill;
      avg_d = raw_sample_i;
    end else begin
      sum_d = sum_norm;
      avg_d = avg_norm;
    end
    held_d = held_q;
    if (abs_diff(held_q, avg_d) > hold_band_q) begin
      held_d = avg_d;
    end
  end

  assign position = held_d + offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      avg_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      sum_q  <= sum_d;
      avg_q  <= avg_d;
      held_q <= held_d;
    end
  end

  // result register and skid stage
  jrah_out_buf #(
    .Width (DataW)
  ) u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (position),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (position_o)
  );

  // average is always the window sum divided by the length, truncated
  a_avg_matches_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SumW+1)'(avg_q) * (SumW+1)'(WINDOW_LENGTH) <= (SumW+1)'(sum_q) &&
    (SumW+1)'(sum_q) - (SumW+1)'(avg_q) * (SumW+1)'(WINDOW_LENGTH)
      < (SumW+1)'(WINDOW_LENGTH))
    else $error("average does not match window sum");

  // held value stays within the band of the average after a request
  a_held_in_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> abs_diff(held_q, avg_q) <= $past(hold_band_q))
    else $error("held value outside hold band");

  // a jump refills the row with the sample: both ends and the average are checked
  a_jump_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && jump |=> oldest == $past(raw_sample_i) &&
                       cell_data[0] == $past(raw_sample_i) &&
                       avg_q == $past(raw_sample_i))
    else $error("jump did not refill window");

  // state only moves on an accepted request
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(sum_q) && $stable(avg_q) && $stable(held_q))
    else $error("filter state changed without a request");

endmodule : jump_reset_average_hysteresis
`default_nettype wire
